// File: hw/rtl/slm_pkg.sv
// Shared types for the sorted list merge block.
// Holds the controller state enum and the command and status bundles.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slm_pkg;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PREP,
    ST_PICK
  } slm_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // an input beat is accepted this cycle
    logic pick;   // emit one merged element into the output register
    logic clear;  // return counts, flags and pointers to reset values
  } slm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic both_closed;
    logic empty;      // both lists hold no element
    logic out_free;   // output register can take a beat this cycle
    logic last_pick;  // the next pick is the final element of the run
    logic l_avail;
    logic r_avail;
  } slm_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/slm_datapath.sv
// Datapath of the sorted list merge: both list stores, counts, merge
// pointers, compare and the output register. Uses slm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slm_datapath
  import slm_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire slm_cmd_t           cmd_i,
  output slm_status_t             status_o,
  input  wire logic               list_select_i,
  input  wire logic signed [31:0] element_value_i,
  input  wire logic               is_last_i,
  input  wire logic               no_element_i,
  input  wire logic               out_stall_i,
  output logic                    out_valid_o,
  output logic signed [31:0]      merged_value_o,
  output logic                    from_right_o,
  output logic                    is_last_out_o,
  output logic                    overflow_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int OW = (WIDTH < 32) ? WIDTH : 32;
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  logic [WIDTH-1:0] left_mem [DEPTH];
  logic [WIDTH-1:0] right_mem [DEPTH];
  logic [WIDTH-1:0] rd_l_q, rd_r_q;

  logic [CW-1:0] lcnt_q, lcnt_d, rcnt_q, rcnt_d;
  logic [CW-1:0] li_q, li_d, ri_q, ri_d;
  logic          lclosed_q, lclosed_d, rclosed_q, rclosed_d;
  logic          lost_q, lost_d;

  logic [WIDTH-1:0] in_val;
  logic [31:0]      pick_val;
  logic             take_left;
  logic [CW:0]      total, done_next;
  logic             sel_closed, sel_full;
  logic             wr_l, wr_r;

  logic              out_valid_q, out_valid_d;
  logic signed [31:0] out_val_q;
  logic              out_right_q, out_last_q, out_ovf_q;

  always_comb begin
    in_val = '0;
    in_val[OW-1:0] = element_value_i[OW-1:0];
  end

  assign sel_closed = list_select_i ? rclosed_q : lclosed_q;
  assign sel_full   = list_select_i ? (rcnt_q == FULL) : (lcnt_q == FULL);
  assign wr_l = cmd_i.load && !sel_closed && !no_element_i && !list_select_i && !sel_full;
  assign wr_r = cmd_i.load && !sel_closed && !no_element_i && list_select_i && !sel_full;

  // Stores with registered reads at the merge pointers.
  always_ff @(posedge clk_i) begin
    if (wr_l) begin
      left_mem[lcnt_q[AW-1:0]] <= in_val;
    end
    if (wr_r) begin
      right_mem[rcnt_q[AW-1:0]] <= in_val;
    end
    rd_l_q <= left_mem[li_q[AW-1:0]];
    rd_r_q <= right_mem[ri_q[AW-1:0]];
  end

  assign total     = {1'b0, lcnt_q} + {1'b0, rcnt_q};
  assign done_next = {1'b0, li_q} + {1'b0, ri_q} + (CW + 1)'(1);

  assign status_o.l_avail     = li_q < lcnt_q;
  assign status_o.r_avail     = ri_q < rcnt_q;
  assign status_o.both_closed = lclosed_q && rclosed_q;
  assign status_o.empty       = (total == '0);
  assign status_o.out_free    = !out_valid_q || !out_stall_i;
  assign status_o.last_pick   = (done_next == total);

  // Ties go to the right list.
  assign take_left = status_o.l_avail &&
                     (!status_o.r_avail || ($signed(rd_l_q) < $signed(rd_r_q)));

  always_comb begin
    pick_val = '0;
    pick_val[OW-1:0] = take_left ? rd_l_q[OW-1:0] : rd_r_q[OW-1:0];
  end

  always_comb begin
    lcnt_d    = lcnt_q;
    rcnt_d    = rcnt_q;
    li_d      = li_q;
    ri_d      = ri_q;
    lclosed_d = lclosed_q;
    rclosed_d = rclosed_q;
    lost_d    = lost_q;
    if (cmd_i.load && !sel_closed) begin
      if (wr_l) begin
        lcnt_d = lcnt_q + CW'(1);
      end
      if (wr_r) begin
        rcnt_d = rcnt_q + CW'(1);
      end
      if (!no_element_i && sel_full) begin
        lost_d = 1'b1;
      end
      if (is_last_i) begin
        if (list_select_i) begin
          rclosed_d = 1'b1;
        end else begin
          lclosed_d = 1'b1;
        end
      end
    end
    if (cmd_i.pick) begin
      if (take_left) begin
        li_d = li_q + CW'(1);
      end else begin
        ri_d = ri_q + CW'(1);
      end
    end
    if (cmd_i.clear) begin
      lcnt_d    = '0;
      rcnt_d    = '0;
      li_d      = '0;
      ri_d      = '0;
      lclosed_d = 1'b0;
      rclosed_d = 1'b0;
      lost_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcnt_q    <= '0;
      rcnt_q    <= '0;
      li_q      <= '0;
      ri_q      <= '0;
      lclosed_q <= 1'b0;
      rclosed_q <= 1'b0;
      lost_q    <= 1'b0;
    end else begin
      lcnt_q    <= lcnt_d;
      rcnt_q    <= rcnt_d;
      li_q      <= li_d;
      ri_q      <= ri_d;
      lclosed_q <= lclosed_d;
      rclosed_q <= rclosed_d;
      lost_q    <= lost_d;
    end
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.pick) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pick) begin
      out_val_q   <= pick_val;
      out_right_q <= !take_left;
      out_last_q  <= status_o.last_pick;
      out_ovf_q   <= lost_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign merged_value_o = out_val_q;
  assign from_right_o   = out_right_q;
  assign is_last_out_o  = out_last_q;
  assign overflow_o     = out_ovf_q;

endmodule

`default_nettype wire

// File: hw/rtl/slm_ctrl.sv
// Controller of the sorted list merge: sequences loading, merge steps
// and the return to reset. Uses slm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slm_ctrl
  import slm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire slm_status_t status_i,
  output slm_cmd_t         cmd_o
);

  slm_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (status_i.both_closed && !status_i.empty) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        state_d = ST_PICK;
      end
      ST_PICK: begin
        if (status_i.out_free) begin
          state_d = status_i.last_pick ? ST_LOAD : ST_PREP;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    cmd_o      = '0;
    case (state_q)
      ST_LOAD: begin
        in_stall_o = status_i.both_closed;
        cmd_o.load = in_valid_i && !status_i.both_closed;
        // Two empty lists close without a run.
        cmd_o.clear = status_i.both_closed && status_i.empty;
      end
      ST_PICK: begin
        cmd_o.pick  = status_i.out_free;
        cmd_o.clear = status_i.out_free && status_i.last_pick;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sorted_list_merge.sv
// Channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_stall_o  | list_select, element_value, is_last, no_element
// out     | output    | out_valid_o / out_stall_i| merged_value, from_right, is_last_out, overflow
//
// Loading accepts one input beat per cycle while in_stall_o is low. Closing the second
// list leads to ST_PREP; each merged element then passes ST_PREP, the registered store
// read at the merge pointers, and ST_PICK, compare and output load.
// Reset (rst_ni, asynchronous) empties both lists; store contents are not cleared.
// A stalled output register only holds the merge; input is stalled during the run.
// Top level: joins the controller and the datapath. Uses slm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_merge
  import slm_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               list_select_i,
  input  wire logic signed [31:0] element_value_i,
  input  wire logic               is_last_i,
  input  wire logic               no_element_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      merged_value_o,
  output logic                    from_right_o,
  output logic                    is_last_out_o,
  output logic                    overflow_o
);

  slm_cmd_t    cmd;
  slm_status_t status;

  slm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  slm_datapath #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .list_select_i   (list_select_i),
    .element_value_i (element_value_i),
    .is_last_i       (is_last_i),
    .no_element_i    (no_element_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .merged_value_o  (merged_value_o),
    .from_right_o    (from_right_o),
    .is_last_out_o   (is_last_out_o),
    .overflow_o      (overflow_o)
  );

  // A merge step never overwrites a beat that is still waiting.
  a_pick_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pick |-> status.out_free)
    else $error("merge step while output beat still waiting");

  // A merge step always has an element to take.
  a_pick_avail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pick |-> (status.l_avail || status.r_avail))
    else $error("merge step with both lists exhausted");

  // No input is taken once both lists are closed.
  a_no_load_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.both_closed |-> !cmd.load)
    else $error("input accepted after both lists closed");

  // The final step of a run leaves the block empty and open.
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.pick && status.last_pick) |=> (!status.both_closed && status.empty))
    else $error("block not cleared after the final merge step");

endmodule

`default_nettype wire

// File: test/tb_sorted_list_merge.sv
// Self-checking testbench for sorted_list_merge: loads pairs of lists and checks the merged run.
// Holds its own merge predictor, a queued driver, an output monitor and random stall on both sides.
// Depends only on the sorted_list_merge RTL.
`timescale 1ns / 1ps

module tb_sorted_list_merge;

  localparam int DEPTH = 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;
  localparam logic LIST_LEFT = 1'b0;
  localparam logic LIST_RIGHT = 1'b1;

  typedef struct {
    logic              sel;
    logic signed [31:0] val;
    logic              last;
    logic              bare;
    bit                wait_drain;  // present only once every merged beat has come back
  } list_item_t;

  typedef struct {
    logic signed [31:0] value;
    logic              right;
    logic              last;
    logic              ovf;
  } merge_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic list_select_i = 1'b0;
  logic signed [31:0] element_value_i = '0;
  logic is_last_i = 1'b0;
  logic no_element_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] merged_value_o;
  logic from_right_o;
  logic is_last_out_o;
  logic overflow_o;

  list_item_t  list_items[$];
  merge_beat_t merge_expect[$];
  list_item_t  cur_item;

  // Predictor state.
  logic signed [31:0] l_store [DEPTH];
  logic signed [31:0] r_store [DEPTH];
  int l_cnt = 0;
  int r_cnt = 0;
  bit l_closed = 0;
  bit r_closed = 0;
  bit lost = 0;

  int errors = 0;
  int planned = 0;
  int loaded_cnt = 0;
  int beats_seen = 0;
  int cycles = 0;
  int hold_cnt = 0;
  bit hold_done = 0;
  logic calm;

  // A window where neither side idles at random.
  assign calm = (loaded_cnt >= 150) && (loaded_cnt < 260);

  sorted_list_merge #(
    .DEPTH(DEPTH),
    .WIDTH(32)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .list_select_i  (list_select_i),
    .element_value_i(element_value_i),
    .is_last_i      (is_last_i),
    .no_element_i   (no_element_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .merged_value_o (merged_value_o),
    .from_right_o   (from_right_o),
    .is_last_out_o  (is_last_out_o),
    .overflow_o     (overflow_o)
  );

  always #10 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    if (errors < 30) begin
      $display("mismatch at cycle %0d: %s", cycles, msg);
    end
    errors++;
  endtask

  function automatic void predict_merge(input list_item_t it);
    int li;
    int ri;
    int total;
    bit take_left;
    merge_beat_t b;
    li = 0;
    ri = 0;
    if ((it.sel == LIST_RIGHT) ? r_closed : l_closed) return;
    if (!it.bare) begin
      if (it.sel == LIST_RIGHT) begin
        if (r_cnt < DEPTH) begin
          r_store[r_cnt] = it.val;
          r_cnt++;
        end else lost = 1;
      end else begin
        if (l_cnt < DEPTH) begin
          l_store[l_cnt] = it.val;
          l_cnt++;
        end else lost = 1;
      end
    end
    if (it.last) begin
      if (it.sel == LIST_RIGHT) r_closed = 1;
      else l_closed = 1;
    end
    if (!(l_closed && r_closed)) return;
    total = l_cnt + r_cnt;
    for (int k = 0; k < total; k++) begin
      // Left wins only when strictly smaller, so ties go to the right list.
      if (li < l_cnt && ri < r_cnt) take_left = l_store[li] < r_store[ri];
      else take_left = li < l_cnt;
      if (take_left) begin
        b.value = l_store[li];
        b.right = LIST_LEFT;
        li++;
      end else begin
        b.value = r_store[ri];
        b.right = LIST_RIGHT;
        ri++;
      end
      b.last = (k + 1 == total);
      b.ovf = lost;
      merge_expect.push_back(b);
    end
    l_cnt = 0;
    r_cnt = 0;
    l_closed = 0;
    r_closed = 0;
    lost = 0;
  endfunction

  task automatic push_item(input logic sel, input logic signed [31:0] val, input logic last,
                           input logic bare);
    list_item_t it;
    it.sel = sel;
    it.val = val;
    it.last = last;
    it.bare = bare;
    it.wait_drain = 0;
    list_items.push_back(it);
  endtask

  // One pair of lists, interleaved at random, with bare items and beats for a
  // list that is already closed mixed in as noise.
  task automatic add_pair(input int nl, input int nr, input bit wide, input bit ordered,
                          input bit drain_first);
    int lv[$];
    int rv[$];
    list_item_t lq[$];
    list_item_t rq[$];
    list_item_t it;
    list_item_t junk;
    bit pick_right;
    for (int i = 0; i < nl; i++) lv.push_back(wide ? int'($urandom) : int'($urandom_range(15)) - 8);
    for (int i = 0; i < nr; i++) rv.push_back(wide ? int'($urandom) : int'($urandom_range(15)) - 8);
    if (ordered) begin
      lv.sort();
      rv.sort();
    end
    it.wait_drain = 0;
    it.last = 0;
    it.bare = 0;
    it.sel = LIST_LEFT;
    foreach (lv[i]) begin
      it.val = lv[i];
      lq.push_back(it);
    end
    it.sel = LIST_RIGHT;
    foreach (rv[i]) begin
      it.val = rv[i];
      rq.push_back(it);
    end
    // Close each list on its final element or with a separate closing beat.
    if (nl > 0 && $urandom_range(1)) lq[lq.size() - 1].last = 1;
    else begin
      it.sel = LIST_LEFT;
      it.val = $urandom;
      it.last = 1;
      it.bare = 1;
      lq.push_back(it);
    end
    if (nr > 0 && $urandom_range(1)) rq[rq.size() - 1].last = 1;
    else begin
      it.sel = LIST_RIGHT;
      it.val = $urandom;
      it.last = 1;
      it.bare = 1;
      rq.push_back(it);
    end
    planned += lq.size() + rq.size();
    while (lq.size() != 0 || rq.size() != 0) begin
      if (lq.size() == 0) pick_right = 1;
      else if (rq.size() == 0) pick_right = 0;
      else pick_right = 1'($urandom_range(1));
      it = pick_right ? rq.pop_front() : lq.pop_front();
      it.wait_drain = drain_first;
      drain_first = 0;
      list_items.push_back(it);
      if ($urandom_range(9) == 0) begin
        push_item(1'($urandom_range(1)), $urandom, 1'b0, 1'b1);
        planned++;
      end
      if (it.last && (pick_right ? lq.size() : rq.size()) != 0 && $urandom_range(3) == 0) begin
        junk.sel = it.sel;
        junk.val = $urandom;
        junk.last = 1'($urandom_range(1));
        junk.bare = 1'($urandom_range(1));
        junk.wait_drain = 0;
        list_items.push_back(junk);
        planned++;
      end
    end
  endtask

  // Driver: a new beat is offered only when the current one is accepted or none is up.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_merge(cur_item);
        loaded_cnt <= loaded_cnt + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (list_items.size() != 0 && !(list_items[0].wait_drain && merge_expect.size() != 0)
            && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          cur_item = list_items.pop_front();
          list_select_i <= cur_item.sel;
          element_value_i <= cur_item.val;
          is_last_i <= cur_item.last;
          no_element_i <= cur_item.bare;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, with one long hold-off once the first results have come.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_stall_i <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && beats_seen >= 60) begin
      hold_done <= 1;
      hold_cnt <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin : monitor
    merge_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_seen <= beats_seen + 1;
      if (merge_expect.size() == 0) begin
        report_mismatch($sformatf("unexpected beat value %0d", merged_value_o));
      end else begin
        want = merge_expect.pop_front();
        if (merged_value_o !== want.value)
          report_mismatch($sformatf("merged_value %0d, want %0d", merged_value_o, want.value));
        if (from_right_o !== want.right)
          report_mismatch($sformatf("from_right %b, want %b", from_right_o, want.right));
        if (is_last_out_o !== want.last)
          report_mismatch($sformatf("is_last_out %b, want %b", is_last_out_o, want.last));
        if (overflow_o !== want.ovf)
          report_mismatch($sformatf("overflow %b, want %b", overflow_o, want.ovf));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[sorted_list_merge] ERROR");
      $finish;
    end
  end

  initial begin
    int r;
    int nl;
    int nr;
    // Extremes of the value range, with ties at the bottom.
    push_item(LIST_LEFT, 32'sh8000_0000, 1'b0, 1'b0);
    push_item(LIST_RIGHT, 32'sh8000_0000, 1'b0, 1'b0);
    push_item(LIST_LEFT, 32'sd0, 1'b1, 1'b0);
    push_item(LIST_RIGHT, 32'sh7fff_ffff, 1'b1, 1'b0);
    // Both lists empty: nothing comes out.
    push_item(LIST_LEFT, 32'sh5a5a_a5a5, 1'b1, 1'b1);
    push_item(LIST_RIGHT, 32'sh0f0f_f0f0, 1'b1, 1'b1);
    // A bare beat does nothing; a beat for a closed list is dropped.
    push_item(LIST_LEFT, -32'sd1, 1'b0, 1'b1);
    push_item(LIST_LEFT, 32'sd5, 1'b1, 1'b0);
    push_item(LIST_LEFT, 32'sd7, 1'b0, 1'b0);
    push_item(LIST_RIGHT, 32'sd0, 1'b1, 1'b1);
    // Left list empty.
    push_item(LIST_RIGHT, -32'sd3, 1'b0, 1'b0);
    push_item(LIST_RIGHT, 32'sd9, 1'b0, 1'b0);
    push_item(LIST_LEFT, 32'sd0, 1'b1, 1'b1);
    push_item(LIST_RIGHT, 32'sd9, 1'b1, 1'b0);
    // Left closed by its own beat after the elements, tie against the right.
    push_item(LIST_LEFT, -32'sd1, 1'b0, 1'b0);
    push_item(LIST_LEFT, 32'sd4, 1'b0, 1'b0);
    push_item(LIST_LEFT, 32'sd0, 1'b1, 1'b1);
    push_item(LIST_RIGHT, -32'sd1, 1'b1, 1'b0);
    planned = 18;
    // Full stores, lost elements on either side, then random pairs.
    add_pair(34, 3, 1'b1, 1'b1, 1'b1);
    add_pair(2, 33, 1'b0, 1'b1, 1'b0);
    add_pair(DEPTH, DEPTH, 1'b1, 1'b1, 1'b1);
    while (planned < 430) begin
      r = $urandom_range(99);
      if (r < 80) begin
        nl = $urandom_range(8);
        nr = $urandom_range(8);
      end else if (r < 95) begin
        nl = $urandom_range(DEPTH);
        nr = $urandom_range(DEPTH);
      end else begin
        nl = $urandom_range(DEPTH + 4, DEPTH + 1);
        nr = $urandom_range(6);
        if ($urandom_range(1)) begin
          r = nl;
          nl = nr;
          nr = r;
        end
      end
      add_pair(nl, nr, 1'($urandom_range(1)), $urandom_range(19) != 0,
               $urandom_range(5) == 0);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (list_items.size() != 0 || in_valid_i) @(posedge clk_i);
    while (merge_expect.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (merge_expect.size() != 0)
      report_mismatch($sformatf("%0d merged beats never came", merge_expect.size()));
    if (errors == 0) begin
      $display("[sorted_list_merge] OK");
    end else begin
      $display("[sorted_list_merge] ERROR");
    end
    $finish;
  end

endmodule
